>>> rtl/core/rcst_pkg.sv
package rcst_pkg;

    // Reference count width and its saturation value.
    localparam int          CNT_W   = 16;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // Error codes reported with each result.
    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_FULL   = 2'd1;
    localparam logic [1:0] ERR_UNUSED = 2'd2;

    // One input transaction.
    typedef struct packed {
        logic        release_valid;
        logic [3:0]  release_slot;
        logic        acquire_valid;
        logic [31:0] acquire_key;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic       slot_valid;
        logic [3:0] slot_index;
        logic       slot_was_new;
        logic       released_freed;
        logic [4:0] table_size;
        logic [1:0] error_code;
    } t_out_item;

    // Control into the key search unit.
    typedef struct packed {
        logic start;
        logic wr_en;
    } t_srch_ctrl;

    // Status out of the key search unit.
    typedef struct packed {
        logic done;
        logic hit;
    } t_srch_stat;

    // Control into the free slot stack.
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctrl;

endpackage

>>> rtl/core/rcst_key_search.sv
module rcst_key_search
    import rcst_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_srch_ctrl                   i_ctrl,
    input  logic [KEY_BITS-1:0]          i_key,
    input  logic [$clog2(SLOTS+1)-1:0]   i_limit,
    input  logic [SLOTS-1:0]             i_used,
    input  logic [$clog2(SLOTS)-1:0]     i_wr_slot,
    output t_srch_stat                   o_stat,
    output logic [$clog2(SLOTS)-1:0]     o_hit_slot
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [KEY_BITS-1:0] key_mem [SLOTS];
    logic [KEY_BITS-1:0] r_key_rd;
    logic                r_busy;
    logic [CW-1:0]       r_rd_idx;
    logic [SW-1:0]       r_cmp_idx;
    logic                r_cmp_vld;
    logic                hit_now;
    logic                end_now;
    logic                issue;

    // One comparator checks the key read in the previous cycle.
    assign hit_now = r_busy && r_cmp_vld && i_used[r_cmp_idx] && (r_key_rd == i_key);
    assign end_now = r_busy && !hit_now && (r_rd_idx >= i_limit);
    assign issue   = r_busy && !hit_now && (r_rd_idx < i_limit);

    assign o_stat.done = hit_now || end_now;
    assign o_stat.hit  = hit_now;
    assign o_hit_slot  = r_cmp_idx;

    // Walk sequencer: one key read issued per cycle, lowest index first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
        end else if (i_ctrl.start) begin
            r_busy    <= 1'b1;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
        end else if (hit_now || end_now) begin
            r_busy    <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else if (issue) begin
            r_rd_idx  <= r_rd_idx + CW'(1);
            r_cmp_vld <= 1'b1;
        end
    end

    // Key memory with one write port and a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            key_mem[i_wr_slot] <= i_key;
        end
        if (issue) begin
            r_key_rd  <= key_mem[r_rd_idx[SW-1:0]];
            r_cmp_idx <= r_rd_idx[SW-1:0];
        end
    end

endmodule

>>> rtl/core/rcst_free_stack.sv
module rcst_free_stack
    import rcst_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_stk_ctrl                    i_ctrl,
    input  logic [$clog2(SLOTS)-1:0]     i_push_slot,
    output logic [$clog2(SLOTS+1)-1:0]   o_depth,
    output logic [$clog2(SLOTS)-1:0]     o_top
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [SW-1:0] stk_mem [SLOTS];
    logic [CW-1:0] r_depth;
    logic [SW-1:0] r_top;
    logic [CW-1:0] pop_pos;
    logic          can_push;

    assign pop_pos  = r_depth - CW'(1);
    assign can_push = r_depth < CW'(SLOTS);
    assign o_depth  = r_depth;
    assign o_top    = r_top;

    // Stack pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (i_ctrl.push && can_push) begin
            r_depth <= r_depth + CW'(1);
        end else if (i_ctrl.pop) begin
            r_depth <= pop_pos;
        end
    end

    // Stack memory; the popped entry is registered and ready in the cycle after the pop.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && can_push) begin
            stk_mem[r_depth[SW-1:0]] <= i_push_slot;
        end
        if (i_ctrl.pop) begin
            r_top <= stk_mem[pop_pos[SW-1:0]];
        end
    end

endmodule

>>> rtl/core/refcounted_slot_table.sv
// A transaction passes through an optional release write and, with an acquire,
// a key search that reads one slot per cycle, then a slot allocation from the
// free stack or the table end, or a count read and increment on a hit. A new
// transaction is taken only after the last result has entered the output
// register; a full output register holds the result and the sequencer until the consumer takes it.
// Reset (synchronous, active low) clears slot use flags, stack depth and
// table size; key, count and stack memories need no clearing pass.
module refcounted_slot_table
    import rcst_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int KEY_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_result
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_REL_WR,
        S_ACQ,
        S_SEARCH,
        S_POP,
        S_ALLOC,
        S_HIT_RD,
        S_HIT_WR,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [SLOTS-1:0]    r_used;
    logic [CW-1:0]       r_size;
    logic                r_rel_err;
    logic [SW-1:0]       r_rel_idx;
    logic                r_acq;
    logic [KEY_BITS-1:0] r_key;
    logic [SW-1:0]       r_slot;
    logic                r_slot_valid;
    logic                r_new;
    logic                r_freed;
    logic                r_full;
    logic                r_out_valid;
    t_out_item           r_out;
    logic                out_load;

    logic [CNT_W-1:0]    cnt_mem [SLOTS];
    logic [CNT_W-1:0]    r_cnt_rd;
    logic [CNT_W-1:0]    cnt_dec;
    logic [CNT_W-1:0]    cnt_inc;
    logic [CNT_W-1:0]    cnt_wd;
    logic [SW-1:0]       cnt_ra;
    logic [SW-1:0]       cnt_wa;
    logic                cnt_we;

    logic [8:0]          rel_ext;
    logic [SW-1:0]       rel_idx;
    logic                rel_in_range;
    logic                rel_ok;

    t_srch_ctrl          srch_ctrl;
    t_srch_stat          srch_stat;
    logic [SW-1:0]       srch_slot;
    t_stk_ctrl           stk_ctrl;
    logic [CW-1:0]       stk_depth;
    logic [SW-1:0]       stk_top;

    // Release decode on the incoming transaction.
    assign rel_ext      = 9'(i_item.release_slot);
    assign rel_idx      = rel_ext[SW-1:0];
    assign rel_in_range = rel_ext < 9'(SLOTS);
    assign rel_ok       = i_item.release_valid && rel_in_range && r_used[rel_idx];

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // The finished result moves into the output register once it is free.
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // Count update values.
    assign cnt_dec = (r_cnt_rd != '0) ? r_cnt_rd - CNT_W'(1) : '0;
    assign cnt_inc = (r_cnt_rd == CNT_MAX) ? r_cnt_rd : r_cnt_rd + CNT_W'(1);

    // Count memory port selection.
    always_comb begin
        cnt_ra = (r_state == S_IDLE) ? rel_idx : r_slot;
        cnt_we = 1'b0;
        cnt_wa = r_slot;
        cnt_wd = CNT_W'(1);
        unique case (r_state)
            S_REL_WR: begin
                cnt_we = 1'b1;
                cnt_wa = r_rel_idx;
                cnt_wd = cnt_dec;
            end
            S_HIT_WR: begin
                cnt_we = 1'b1;
                cnt_wd = cnt_inc;
            end
            S_ALLOC: begin
                cnt_we = 1'b1;
            end
            default: begin
                cnt_we = 1'b0;
            end
        endcase
    end

    // Count memory with a registered read.
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        r_cnt_rd <= cnt_mem[cnt_ra];
    end

    // Controls toward the search unit and the free stack.
    always_comb begin
        srch_ctrl.start = (r_state == S_ACQ) && r_acq;
        srch_ctrl.wr_en = (r_state == S_ALLOC);
        stk_ctrl.push   = (r_state == S_REL_WR) && (cnt_dec == '0);
        stk_ctrl.pop    = (r_state == S_SEARCH) && srch_stat.done && !srch_stat.hit
                          && (stk_depth != '0);
    end

    rcst_key_search #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (srch_ctrl),
        .i_key      (r_key),
        .i_limit    (r_size),
        .i_used     (r_used),
        .i_wr_slot  (r_slot),
        .o_stat     (srch_stat),
        .o_hit_slot (srch_slot)
    );

    rcst_free_stack #(
        .SLOTS (SLOTS)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (stk_ctrl),
        .i_push_slot (r_rel_idx),
        .o_depth     (stk_depth),
        .o_top       (stk_top)
    );

    // Sequencer, slot flags and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_size      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_rel_err    <= i_item.release_valid
                                        && !(rel_in_range && r_used[rel_idx]);
                        r_rel_idx    <= rel_idx;
                        r_acq        <= i_item.acquire_valid;
                        r_key        <= KEY_BITS'(i_item.acquire_key);
                        r_slot_valid <= 1'b0;
                        r_new        <= 1'b0;
                        r_freed      <= 1'b0;
                        r_full       <= 1'b0;
                        r_state      <= rel_ok ? S_REL_WR : S_ACQ;
                    end
                end
                S_REL_WR: begin
                    if (cnt_dec == '0) begin
                        r_used[r_rel_idx] <= 1'b0;
                        r_freed           <= 1'b1;
                    end
                    r_state <= S_ACQ;
                end
                S_ACQ: begin
                    r_state <= r_acq ? S_SEARCH : S_DONE;
                end
                S_SEARCH: begin
                    if (srch_stat.done) begin
                        if (srch_stat.hit) begin
                            r_slot  <= srch_slot;
                            r_state <= S_HIT_RD;
                        end else if (stk_depth != '0) begin
                            r_state <= S_POP;
                        end else if (r_size < CW'(SLOTS)) begin
                            r_slot  <= r_size[SW-1:0];
                            r_size  <= r_size + CW'(1);
                            r_state <= S_ALLOC;
                        end else begin
                            r_full  <= 1'b1;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_POP: begin
                    r_slot  <= stk_top;
                    r_state <= S_ALLOC;
                end
                S_ALLOC: begin
                    r_used[r_slot] <= 1'b1;
                    r_slot_valid   <= 1'b1;
                    r_new          <= 1'b1;
                    r_state        <= S_DONE;
                end
                S_HIT_RD: begin
                    r_state <= S_HIT_WR;
                end
                S_HIT_WR: begin
                    r_slot_valid <= 1'b1;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out.slot_valid     <= r_slot_valid;
                        r_out.slot_index     <= r_slot_valid ? 4'(r_slot) : 4'd0;
                        r_out.slot_was_new   <= r_new;
                        r_out.released_freed <= r_freed;
                        r_out.table_size     <= 5'(r_size);
                        r_out.error_code     <= r_full    ? ERR_FULL :
                                                r_rel_err ? ERR_UNUSED : ERR_OK;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> tb/slot_table_checker.sv
`timescale 1ns / 1ps

module slot_table_checker
    import rcst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    input  logic      i_req_ready,
    input  t_in_item  i_req,
    input  logic      i_res_valid,
    input  logic      i_res_ready,
    input  t_out_item i_res,
    output int        o_mismatches,
    output int        o_outstanding
);

    localparam int SLOT_COUNT = 16;

    // Shadow copy of the slot table.
    logic [31:0]      shadow_key  [SLOT_COUNT];
    logic             shadow_busy [SLOT_COUNT];
    logic [CNT_W-1:0] shadow_uses [SLOT_COUNT];
    logic [3:0]       free_lifo   [SLOT_COUNT];
    int               free_top;
    int               high_mark;

    t_out_item expected_results[$];
    t_out_item oldest;
    int        mismatch_count = 0;
    int        outstanding    = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = outstanding;

    // Apply one request to the shadow table and return the slot it should report.
    function automatic t_out_item predict_slot_result(input t_in_item req);
        t_out_item  res;
        logic [3:0] rel;
        logic       hit;
        int         found;
        int         pick;
        res            = '0;
        res.error_code = ERR_OK;

        // The release is applied before the lookup.
        if (req.release_valid) begin
            rel = req.release_slot;
            if (shadow_busy[rel]) begin
                if (shadow_uses[rel] != '0) begin
                    shadow_uses[rel] = shadow_uses[rel] - 1'b1;
                end
                if (shadow_uses[rel] == '0) begin
                    shadow_busy[rel]   = 1'b0;
                    res.released_freed = 1'b1;
                    if (free_top < SLOT_COUNT) begin
                        free_lifo[free_top] = rel;
                        free_top++;
                    end
                end
            end else begin
                res.error_code = ERR_UNUSED;
            end
        end

        // Lookup takes the lowest used slot holding the key.
        if (req.acquire_valid) begin
            hit   = 1'b0;
            found = 0;
            for (int i = 0; i < high_mark; i++) begin
                if (!hit && shadow_busy[i] && shadow_key[i] == req.acquire_key) begin
                    hit   = 1'b1;
                    found = i;
                end
            end
            if (hit) begin
                // The count saturates rather than wrapping.
                if (shadow_uses[found] != CNT_MAX) begin
                    shadow_uses[found] = shadow_uses[found] + 1'b1;
                end
                res.slot_valid = 1'b1;
                res.slot_index = found[3:0];
            end else begin
                // A miss reuses the most recently freed slot, else grows the table.
                pick = -1;
                if (free_top > 0) begin
                    free_top--;
                    pick = int'(free_lifo[free_top]);
                end else if (high_mark < SLOT_COUNT) begin
                    pick = high_mark;
                    high_mark++;
                end
                if (pick >= 0) begin
                    shadow_key[pick]  = req.acquire_key;
                    shadow_busy[pick] = 1'b1;
                    shadow_uses[pick] = CNT_W'(1);
                    res.slot_valid    = 1'b1;
                    res.slot_index    = pick[3:0];
                    res.slot_was_new  = 1'b1;
                end else begin
                    res.error_code = ERR_FULL;
                end
            end
        end

        res.table_size = high_mark[4:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            report_mismatch($sformatf("%s expected %0h got %0h", field, want, got));
        end
    endtask

    // Watch both channels on the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                shadow_busy[i] = 1'b0;
                shadow_uses[i] = '0;
            end
            free_top  = 0;
            high_mark = 0;
            expected_results.delete();
        end else begin
            // Compare a delivered result with the oldest expectation first.
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %h with no transaction pending",
                                              i_res));
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("slot_valid", 8'(oldest.slot_valid),
                                8'(i_res.slot_valid));
                    check_field("slot_index", 8'(oldest.slot_index),
                                8'(i_res.slot_index));
                    check_field("slot_was_new", 8'(oldest.slot_was_new),
                                8'(i_res.slot_was_new));
                    check_field("released_freed", 8'(oldest.released_freed),
                                8'(i_res.released_freed));
                    check_field("table_size", 8'(oldest.table_size),
                                8'(i_res.table_size));
                    check_field("error_code", 8'(oldest.error_code),
                                8'(i_res.error_code));
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_results.insert(expected_results.size(),
                                        predict_slot_result(i_req));
            end
        end
        outstanding = expected_results.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rcst_pkg::*;

    localparam int          POOL_SIZE        = 20;
    localparam int          RANDOM_PER_PHASE = 275;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_result;

    int          mismatches;
    int          outstanding;
    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    logic [31:0] key_pool [POOL_SIZE];

    refcounted_slot_table uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    slot_table_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_req         (i_item),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_res         (o_result),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // The result consumer stalls at random.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Offer one request and hold it until the block accepts the transaction.
    task automatic send_request(input logic rel_v, input logic [3:0] rel_slot,
                                input logic acq_v, input logic [31:0] key);
        t_in_item req;
        req.release_valid = rel_v;
        req.release_slot  = rel_slot;
        req.acquire_valid = acq_v;
        req.acquire_key   = key;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= req;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Mostly pooled keys so that hits, reuse and a full table all occur.
    task automatic send_random_request();
        logic [31:0] key;
        key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                        : $urandom;
        send_request($urandom_range(99) < 60, 4'($urandom_range(15)),
                     $urandom_range(99) < 60, key);
    endtask

    initial begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++) begin
            key_pool[k] = $urandom;
        end

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases: idle request, bad release, reuse, append, hits, full table.
        send_request(1'b0, 4'd0, 1'b0, '0);
        send_request(1'b1, 4'd15, 1'b0, '0);
        send_request(1'b0, 4'd0, 1'b1, 32'h0000_0000);
        send_request(1'b0, 4'd0, 1'b1, 32'hFFFF_FFFF);
        send_request(1'b0, 4'd0, 1'b1, 32'h0000_0000);
        send_request(1'b1, 4'd0, 1'b1, 32'h0000_0000);
        send_request(1'b1, 4'd1, 1'b1, 32'hFFFF_FFFF);
        for (int k = 1; k <= 14; k++) begin
            send_request(1'b0, 4'd0, 1'b1, 32'(k));
        end
        send_request(1'b0, 4'd0, 1'b1, 32'h1234_5678);
        send_request(1'b1, 4'd3, 1'b1, 32'h1234_5678);
        send_request(1'b1, 4'd3, 1'b0, '0);
        send_request(1'b1, 4'd3, 1'b0, '0);
        send_request(1'b0, 4'd0, 1'b1, 32'hDEAD_BEEF);

        // Random traffic under each idling pattern.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 63;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 63;
                end
                default: begin
                    sender_idle_pct    = 27;
                    receiver_stall_pct = 27;
                end
            endcase
            repeat (RANDOM_PER_PHASE) send_random_request();
        end
        i_valid <= 1'b0;

        // Drain, then allow for any stray late result.
        while (outstanding != 0) begin
            @(negedge i_clk);
        end
        repeat (30) @(negedge i_clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("refcounted_slot_table verification clean");
        end else begin
            $display("refcounted_slot_table verification failed");
        end
        $finish;
    end

    // Watchdog in case the block stops responding.
    initial begin
        #250_000_000;
        $display("refcounted_slot_table verification failed");
        $finish;
    end

endmodule
